### src/tvi_pkg.sv
// tvi_pkg: shared types and constants of the timed velocity interpolator
// used by the core, the arithmetic unit and the port checker; no dependencies

package tvi_pkg;

  localparam int TVI_MAX_POINTS = 64;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACK  = 3'd0,
    ST_CMD  = 3'd1,
    ST_DONE = 3'd2,
    ST_ERR  = 3'd3,
    ST_FULL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_SEG,
    S_AXIS,
    S_FIN
  } core_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_SUM
  } arith_state_t;

  // one table entry
  typedef struct packed {
    logic [31:0] time_us;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vrot;
  } entry_t;

  // request to the arithmetic unit: v0 + (v1 - v0) * a / d
  typedef struct packed {
    logic        start;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [32:0] a;
    logic [32:0] d;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } arith_rsp_t;

endpackage

### src/tvi_arith.sv
// tvi_arith: shared multiply / restoring divide / saturate unit, one axis per request
// depends on tvi_pkg for the request, response and state types

module tvi_arith import tvi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  arith_state_t state, state_next;

  logic [31:0] mdv, ma, md, w0;
  logic        neg;
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [5:0]  cnt;

  logic [32:0] dv_w;
  logic [32:0] trial, diff;
  logic        ge;
  logic [33:0] base, qz, s;
  logic [31:0] sat_value;

  function automatic logic [31:0] abs33(input logic [32:0] x);
    logic [32:0] n;
    n = x[32] ? (~x + 33'd1) : x;
    return n[31:0];
  endfunction

  assign dv_w = {req.v1[31], req.v1} - {req.v0[31], req.v0};

  // one restoring divide step
  assign trial = {rem, dvd[63]};
  assign ge    = trial >= {1'b0, md};
  assign diff  = trial - {1'b0, md};

  // signed sum and clamp to 32 bits
  assign base = {{2{w0[31]}}, w0};
  assign qz   = {2'b00, dvd[31:0]};
  assign s    = neg ? (base - qz) : (base + qz);

  always_comb begin
    if (|dvd[63:32]) begin
      sat_value = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      sat_value = s[31:0];
    end else begin
      sat_value = s[33] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  // a new request is also taken in the sum cycle, so axes run back to back
  always_comb begin
    state_next = state;
    case (state)
      A_IDLE:  if (req.start) state_next = A_MUL;
      A_MUL:   state_next = A_DIV;
      A_DIV:   if (cnt == 6'd63) state_next = A_SUM;
      A_SUM:   state_next = req.start ? A_MUL : A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  assign rsp.done  = (state == A_SUM);
  assign rsp.value = sat_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE, A_SUM: begin
        if (req.start) begin
          mdv <= abs33(dv_w);
          ma  <= abs33(req.a);
          md  <= abs33(req.d);
          neg <= dv_w[32] ^ req.a[32] ^ req.d[32];
          w0  <= req.v0;
        end
      end
      A_MUL: begin
        dvd <= 64'(mdv) * 64'(ma);
        rem <= '0;
        cnt <= '0;
      end
      A_DIV: begin
        rem <= ge ? diff[31:0] : trial[31:0];
        dvd <= {dvd[62:0], ge};
        cnt <= cnt + 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/timed_velocity_interpolator_core.sv
// timed_velocity_interpolator_core: top level, point table, sequencer and result register
// depends on tvi_pkg and tvi_arith

// Keeps a table of up to MAX_POINTS timed points (time in microseconds, x, y and
// rotation velocity in signed Q16.16; the fraction width does not enter the math).
// A clear item empties the table, a load item appends a point and acks with the
// index written (status 4 when full), a tick item linearly interpolates the three
// velocities on the first segment whose later point is past the elapsed time, or
// the last segment; a time past the final point gives status 2, fewer than two
// points or a zero-length segment gives status 3. Exactly one result per item.
// Clear, load and unknown modes go from the accept straight to the final state,
// which moves the result into the output register. A tick scans the table one
// entry at a time through the single read port of the point memory, then runs
// per axis a multiply step, 64 restoring divide steps and a sum step in the
// shared arithmetic unit, the axes following each other with no gap. Ticks that
// end early (too few points, past the end, zero-length segment) skip the
// arithmetic. A result held by the receiver stalls the block. The table needs
// no clearing pass after reset.

module timed_velocity_interpolator_core import tvi_pkg::*; #(
  parameter int MAX_POINTS = TVI_MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] time_us,
  input  logic [31:0] vel_x_in,
  input  logic [31:0] vel_y_in,
  input  logic [31:0] vel_rot_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] cmd_x,
  output logic [31:0] cmd_y,
  output logic [31:0] cmd_rot,
  output logic [5:0]  segment_end
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_ROT = 2'd2;

  core_state_t state, state_next;

  // point table: one wide entry per point, one write and one read port
  entry_t mem [MAX_POINTS];
  entry_t rd_entry;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] idx_last;
  logic [IDX_W-1:0] idx;
  logic [31:0]      tick_t;
  entry_t           prev, cur;
  logic [1:0]       ax, ax_sel;

  // working result, moved to the output register when the slot frees
  status_t     res_status;
  logic [31:0] res_x, res_y, res_rot;
  logic [5:0]  res_seg;
  logic        out_load;

  arith_req_t areq;
  arith_rsp_t arsp;
  logic        arith_start;
  logic [32:0] seg_d;

  logic in_acc;

  assign in_acc   = in_valid && in_ready;
  assign cnt_m1   = count - CNT_W'(1);
  assign idx_last = cnt_m1[IDX_W-1:0];
  assign seg_d    = {1'b0, cur.time_us} - {1'b0, prev.time_us};

  // operands for the next axis: axis 0 right after the segment is found
  assign ax_sel = (state == S_SEG) ? AX_X : (ax + 2'd1);

  always_comb begin
    areq.start = arith_start;
    areq.a = {1'b0, tick_t} - {1'b0, prev.time_us};
    areq.d = seg_d;
    case (ax_sel)
      AX_X: begin
        areq.v0 = prev.vx;
        areq.v1 = cur.vx;
      end
      AX_Y: begin
        areq.v0 = prev.vy;
        areq.v1 = cur.vy;
      end
      default: begin
        areq.v0 = prev.vrot;
        areq.v1 = cur.vrot;
      end
    endcase
  end

  tvi_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  // sequencer: next state, memory port and unit start
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    arith_start = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = idx_last;
        if (in_valid) begin
          state_next = S_FIN;
          case (mode)
            MODE_LOAD: wr_en = (count < CNT_W'(MAX_POINTS));
            MODE_TICK: if (count >= CNT_W'(2)) state_next = S_LAST;
            default: begin
            end
          endcase
        end
      end
      S_LAST: begin
        // final point time against the tick time
        rd_addr = '0;
        if (tick_t > rd_entry.time_us) state_next = S_FIN;
        else state_next = S_FIRST;
      end
      S_FIRST: begin
        rd_addr    = IDX_W'(1);
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = idx + IDX_W'(1);
        if (rd_entry.time_us > tick_t || idx == idx_last) state_next = S_SEG;
      end
      S_SEG: begin
        if (seg_d == '0) begin
          state_next = S_FIN;
        end else begin
          arith_start = 1'b1;
          state_next  = S_AXIS;
        end
      end
      S_AXIS: begin
        if (arsp.done) begin
          if (ax == AX_ROT) begin
            state_next = S_FIN;
          end else begin
            arith_start = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // point memory, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= '{time_us: time_us, vx: vel_x_in, vy: vel_y_in,
                                 vrot: vel_rot_in};
    end
    rd_entry <= mem[rd_addr];
  end

  // point count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc && mode == MODE_CLEAR) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CNT_W'(1);
    end
  end

  // datapath of the tick sequence and the working result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          tick_t     <= time_us;
          res_status <= ST_ACK;
          res_x      <= '0;
          res_y      <= '0;
          res_rot    <= '0;
          res_seg    <= '0;
          case (mode)
            MODE_LOAD: begin
              if (count < CNT_W'(MAX_POINTS)) res_seg    <= 6'(count);
              else                            res_status <= ST_FULL;
            end
            MODE_TICK: if (count < CNT_W'(2)) res_status <= ST_ERR;
            default: begin
            end
          endcase
        end
      end
      S_LAST: if (tick_t > rd_entry.time_us) res_status <= ST_DONE;
      S_FIRST: begin
        prev <= rd_entry;
        idx  <= IDX_W'(1);
      end
      S_SCAN: begin
        if (rd_entry.time_us > tick_t || idx == idx_last) begin
          cur <= rd_entry;
        end else begin
          prev <= rd_entry;
          idx  <= idx + IDX_W'(1);
        end
      end
      S_SEG: begin
        ax <= AX_X;
        if (seg_d == '0) begin
          res_status <= ST_ERR;
        end else begin
          res_status <= ST_CMD;
          res_seg    <= 6'(idx);
        end
      end
      S_AXIS: begin
        if (arsp.done) begin
          case (ax)
            AX_X:    res_x   <= arsp.value;
            AX_Y:    res_y   <= arsp.value;
            default: res_rot <= arsp.value;
          endcase
          ax <= ax + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      cmd_x       <= res_x;
      cmd_y       <= res_y;
      cmd_rot     <= res_rot;
      segment_end <= res_seg;
    end
  end

endmodule

### src/tvi_checker.sv
// tvi_checker: port-level assertions for the interpolator core, bound to the top level
// depends on tvi_pkg and timed_velocity_interpolator_core

module tvi_checker import tvi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] cmd_x,
  input logic [31:0] cmd_y,
  input logic [31:0] cmd_rot,
  input logic [5:0]  segment_end
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // a fresh result never appears while the input side was open
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a finished item");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cmd_x)
      && $stable(cmd_y) && $stable(cmd_rot) && $stable(segment_end))
    else $error("stalled result changed");

  // commands are zero unless the status says they are valid
  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_CMD |-> cmd_x == '0 && cmd_y == '0 && cmd_rot == '0)
    else $error("nonzero command without command-valid status");

  // no segment index on error, finished or full results
  a_seg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DONE || status == ST_ERR || status == ST_FULL)
      |-> segment_end == '0)
    else $error("segment index on a result that carries none");

endmodule

bind timed_velocity_interpolator_core tvi_checker u_tvi_checker (.*);
